>>> hdl/serial_frame_decoder_core_macros.svh
// Assertion macros shared by the serial frame decoder checkers.
// No dependencies; included by the checker file.
`ifndef SERIAL_FRAME_DECODER_CORE_MACROS_SVH
`define SERIAL_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial frame decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serial frame decoder check failed");

`endif

>>> hdl/sfd_pkg.sv
// Types and constants for the serial frame decoder.
// No dependencies; used by every module of the block.
package sfd_pkg;

  localparam logic [7:0] SYNC_FIRST    = 8'hAA;
  localparam logic [7:0] SYNC_SECOND   = 8'h55;
  localparam logic [7:0] SIG_BIAS      = 8'h80;
  localparam int         MIN_FRAME     = 18;
  localparam int         HEADER_FIRST  = 3;
  localparam int         HEADER_COUNT  = 13;
  localparam int         PAYLOAD_FIRST = 16;
  localparam int         WORD_BYTES    = 4;
  localparam logic [7:0] LEN_BIAS      = 8'd13;
  localparam logic [7:0] WORD_MIN_LEN  = 8'd17;
  localparam int         DATA_W        = 144;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_BAD_CHECK  = 3'd4
  } status_t;

  typedef struct packed {
    logic                             too_short;
    logic                             start_ok;
    logic                             check_seen;
    logic [7:0]                       xor_sum;
    logic [7:0]                       check_byte;
    logic [7:0]                       frame_length;
    logic [HEADER_COUNT-1:0][7:0]     header;
    logic [31:0]                      data_bytes;
  } frame_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         message_type;
    logic [15:0]        source_id;
    logic [15:0]        destination_id;
    logic [15:0]        via_id;
    logic [7:0]         hop_limit;
    logic [7:0]         spreading_factor;
    logic [7:0]         transmit_power;
    logic [15:0]        carrier_mhz;
    logic signed [7:0]  signal_strength;
    logic [7:0]         payload_length;
    logic [31:0]        data_word;
  } result_t;

endpackage

>>> hdl/serial_frame_decoder_core.sv
// Serial frame decoder: one received byte per transaction, one result per chunk.
// The result is registered: it appears in the cycle after the transaction carrying tlast.
// Throughput: one byte per cycle; input ready only drops while a result waits.
// Reset (rst_n low, synchronous) clears the frame state and drops out_tvalid.
// Depends on sfd_pkg, sfd_accum and sfd_decode.
module serial_frame_decoder_core
  import sfd_pkg::*;
#(
  parameter int MAX_CHUNK = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // rx_byte
  input  logic              in_tlast,   // chunk_end
  output logic              out_tvalid,
  input  logic              out_tready,
  // message_type, source_id, destination_id, via_id, hop_limit, spreading_factor,
  // transmit_power, carrier_mhz, signal_strength, payload_length, data_word
  output logic [DATA_W-1:0] out_tdata,
  output logic [2:0]        out_tuser   // status
);

  logic    acc;
  logic    load;
  logic    out_valid_r, out_valid_nxt;
  frame_t  frame;
  result_t result;
  result_t res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign load      = acc && in_tlast;

  sfd_accum #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_tdata),
    .chunk_end (in_tlast),
    .frame     (frame)
  );

  sfd_decode u_decode (
    .frame  (frame),
    .result (result)
  );

  assign out_valid_nxt = load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = {res_r.data_word, res_r.payload_length, res_r.signal_strength,
                       res_r.carrier_mhz, res_r.transmit_power, res_r.spreading_factor,
                       res_r.hop_limit, res_r.via_id, res_r.destination_id,
                       res_r.source_id, res_r.message_type};

endmodule

>>> hdl/sfd_accum.sv
// Per-byte frame state: sync check, length capture, running XOR and field capture.
// Depends on sfd_pkg; presents the state as it stands after the current byte.
module sfd_accum
  import sfd_pkg::*;
#(
  parameter int MAX_CHUNK = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  input  logic       chunk_end,
  output frame_t     frame
);

  localparam int CNT_W = $clog2(MAX_CHUNK + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [7:0]                    len_r, len_nxt;
  logic [7:0]                    xor_r, xor_nxt;
  logic [7:0]                    chk_r, chk_nxt;
  logic                          seen_r, seen_nxt;
  logic                          start_r, start_nxt;
  logic [HEADER_COUNT-1:0][7:0]  hdr_r, hdr_nxt;
  logic [31:0]                   data_r, data_nxt;
  logic [CMP_W-1:0]              pos;
  logic [CMP_W-1:0]              check_pos;

  always_comb begin
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    chk_nxt   = chk_r;
    seen_nxt  = seen_r;
    start_nxt = start_r;
    hdr_nxt   = hdr_r;
    data_nxt  = data_r;
    pos       = CMP_W'(idx_r);
    check_pos = CMP_W'(len_r) + CMP_W'(3);
    if (acc && (idx_r != CNT_W'(MAX_CHUNK))) begin
      if (pos == CMP_W'(0)) begin
        start_nxt = (rx_byte == SYNC_FIRST);
      end else if (pos == CMP_W'(1)) begin
        start_nxt = start_r && (rx_byte == SYNC_SECOND);
      end else if (pos == CMP_W'(2)) begin
        len_nxt = rx_byte;
        xor_nxt = rx_byte;
      end else if (pos < check_pos) begin
        xor_nxt = xor_r ^ rx_byte;
      end else if (pos == check_pos) begin
        chk_nxt  = rx_byte;
        seen_nxt = 1'b1;
      end
      for (int k = 0; k < HEADER_COUNT; k++) begin
        if (pos == CMP_W'(HEADER_FIRST + k)) begin
          hdr_nxt[k] = rx_byte;
        end
      end
      if ((pos >= CMP_W'(PAYLOAD_FIRST)) && (pos < CMP_W'(PAYLOAD_FIRST + WORD_BYTES))
          && (pos < check_pos)) begin
        data_nxt = {data_r[23:0], rx_byte};
      end
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_comb begin
    frame.too_short    = CMP_W'(idx_nxt) < CMP_W'(MIN_FRAME);
    frame.start_ok     = start_nxt;
    frame.check_seen   = seen_nxt;
    frame.xor_sum      = xor_nxt;
    frame.check_byte   = chk_nxt;
    frame.frame_length = len_nxt;
    frame.header       = hdr_nxt;
    frame.data_bytes   = data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && chunk_end)) begin
      idx_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      chk_r   <= '0;
      seen_r  <= 1'b0;
      start_r <= 1'b1;
      hdr_r   <= '0;
      data_r  <= '0;
    end else begin
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      chk_r   <= chk_nxt;
      seen_r  <= seen_nxt;
      start_r <= start_nxt;
      hdr_r   <= hdr_nxt;
      data_r  <= data_nxt;
    end
  end

endmodule

>>> hdl/sfd_decode.sv
// Result decode: status priority and header field extraction for a closed chunk.
// Depends on sfd_pkg; purely combinational.
module sfd_decode
  import sfd_pkg::*;
(
  input  frame_t  frame,
  output result_t result
);

  status_t status;

  always_comb begin
    if (frame.too_short) begin
      status = ST_SHORT;
    end else if (!frame.start_ok) begin
      status = ST_BAD_START;
    end else if (!frame.check_seen) begin
      status = ST_INCOMPLETE;
    end else if (frame.xor_sum != frame.check_byte) begin
      status = ST_BAD_CHECK;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result        = '0;
    result.status = status;
    if (status == ST_OK) begin
      result.message_type     = frame.header[0];
      result.source_id        = {frame.header[1], frame.header[2]};
      result.destination_id   = {frame.header[3], frame.header[4]};
      result.via_id           = {frame.header[5], frame.header[6]};
      result.hop_limit        = frame.header[7];
      result.spreading_factor = frame.header[8];
      result.transmit_power   = frame.header[9];
      result.carrier_mhz      = {frame.header[10], frame.header[11]};
      result.signal_strength  = $signed(frame.header[12] ^ SIG_BIAS);
      result.payload_length   = (frame.frame_length > LEN_BIAS) ?
                                (frame.frame_length - LEN_BIAS) : 8'd0;
      result.data_word        = (frame.frame_length >= WORD_MIN_LEN) ?
                                frame.data_bytes : 32'd0;
    end
  end

endmodule

>>> hdl/sfd_checker.sv
// Port-level checks for the serial frame decoder, bound to the top level.
// Depends on sfd_pkg and serial_frame_decoder_core_macros.svh.
`include "serial_frame_decoder_core_macros.svh"

module sfd_checker
  import sfd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tlast,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic [2:0]        out_tuser
);

  `SFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `SFD_ASSERT_NXT(a_last_gives_result, clk, rst_n, in_tvalid && in_tready && in_tlast, out_tvalid)
  `SFD_ASSERT_NXT(a_no_spurious_result, clk, rst_n,
                  in_tvalid && in_tready && !in_tlast && !(out_tvalid && !out_tready),
                  !out_tvalid)
  `SFD_ASSERT_IMP(a_failed_fields_zero, clk, rst_n,
                  out_tvalid && (out_tuser != ST_OK), out_tdata == '0)

endmodule

bind serial_frame_decoder_core sfd_checker u_sfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> test/tb_serial_frame_decoder_core.sv
// Self-checking testbench for serial_frame_decoder_core: drives byte chunks, directed and random.
// A scoreboard class predicts one decoded frame per chunk and checks it field by field.
// Depends on sfd_pkg and the serial_frame_decoder_core RTL.
module tb_serial_frame_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sfd_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int CHUNK_LIMIT    = 256;
  localparam int RANDOM_BYTES   = 110;
  localparam int RANDOM_CHUNKS  = 5;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct {
    status_t     status;
    logic [7:0]  message_type;
    logic [15:0] source_id;
    logic [15:0] destination_id;
    logic [15:0] via_id;
    logic [7:0]  hop_limit;
    logic [7:0]  spreading_factor;
    logic [7:0]  transmit_power;
    logic [15:0] carrier_mhz;
    logic [7:0]  signal_strength;
    logic [7:0]  payload_length;
    logic [31:0] data_word;
  } frame_result_t;

  class decoder_scoreboard;
    int            errors;
    frame_result_t decoded_frames[$];
    int            rx_count;
    logic [7:0]    frame_len;
    logic [7:0]    xor_acc;
    logic [7:0]    check_val;
    bit            check_hit;
    bit            sync_ok;
    logic [7:0]    header[HEADER_COUNT];
    logic [31:0]   payload_word;

    function new();
      errors = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      rx_count = 0;
      frame_len = '0;
      xor_acc = '0;
      check_val = '0;
      check_hit = 1'b0;
      sync_ok = 1'b1;
      foreach (header[k]) header[k] = '0;
      payload_word = '0;
    endfunction

    function int pending();
      return decoded_frames.size();
    endfunction

    function void add_rx_byte(logic [7:0] b, logic last);
      int            check_pos;
      frame_result_t r;
      if (rx_count < CHUNK_LIMIT) begin
        check_pos = int'(frame_len) + 3;
        if (rx_count == 0) sync_ok = (b == SYNC_FIRST);
        else if (rx_count == 1) sync_ok = sync_ok && (b == SYNC_SECOND);
        else if (rx_count == 2) begin
          frame_len = b;
          xor_acc = b;
        end else if (rx_count < check_pos) xor_acc ^= b;
        else if (rx_count == check_pos) begin
          check_val = b;
          check_hit = 1'b1;
        end
        if (rx_count >= HEADER_FIRST && rx_count < HEADER_FIRST + HEADER_COUNT)
          header[rx_count - HEADER_FIRST] = b;
        if (rx_count >= PAYLOAD_FIRST && rx_count < PAYLOAD_FIRST + WORD_BYTES &&
            rx_count < check_pos)
          payload_word = {payload_word[23:0], b};
        rx_count++;
      end
      if (!last) return;
      r = '{status: ST_OK, default: '0};
      if (rx_count < MIN_FRAME) r.status = ST_SHORT;
      else if (!sync_ok) r.status = ST_BAD_START;
      else if (!check_hit) r.status = ST_INCOMPLETE;
      else if (xor_acc != check_val) r.status = ST_BAD_CHECK;
      else begin
        r.message_type     = header[0];
        r.source_id        = {header[1], header[2]};
        r.destination_id   = {header[3], header[4]};
        r.via_id           = {header[5], header[6]};
        r.hop_limit        = header[7];
        r.spreading_factor = header[8];
        r.transmit_power   = header[9];
        r.carrier_mhz      = {header[10], header[11]};
        r.signal_strength  = header[12] ^ SIG_BIAS;
        r.payload_length   = (frame_len > LEN_BIAS) ? frame_len - LEN_BIAS : 8'd0;
        r.data_word        = (frame_len >= WORD_MIN_LEN) ? payload_word : 32'd0;
      end
      decoded_frames.insert(decoded_frames.size(), r);
      restart_frame();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_decoded(logic [2:0] st, logic [DATA_W-1:0] d);
      frame_result_t e;
      if (decoded_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d data %h",
                 $time, st, d);
        return;
      end
      e = decoded_frames.pop_front();
      compare_field("status", 32'(e.status), 32'(st));
      compare_field("message_type", 32'(e.message_type), 32'(d[7:0]));
      compare_field("source_id", 32'(e.source_id), 32'(d[23:8]));
      compare_field("destination_id", 32'(e.destination_id), 32'(d[39:24]));
      compare_field("via_id", 32'(e.via_id), 32'(d[55:40]));
      compare_field("hop_limit", 32'(e.hop_limit), 32'(d[63:56]));
      compare_field("spreading_factor", 32'(e.spreading_factor), 32'(d[71:64]));
      compare_field("transmit_power", 32'(e.transmit_power), 32'(d[79:72]));
      compare_field("carrier_mhz", 32'(e.carrier_mhz), 32'(d[95:80]));
      compare_field("signal_strength", 32'(e.signal_strength), 32'(d[103:96]));
      compare_field("payload_length", 32'(e.payload_length), 32'(d[111:104]));
      compare_field("data_word", e.data_word, d[143:112]);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [2:0]        out_tuser;

  decoder_scoreboard sb = new();
  logic [7:0]        chunk[$];
  int                bytes_sent = 0;
  int                chunks_sent = 0;
  int                quiet_cycles = 0;
  int                hold_left = 0;
  bit                idle_on = 1'b1;
  bit                steady_chunk = 1'b0;
  bit                hold_req = 1'b0;

  serial_frame_decoder_core #(.MAX_CHUNK(CHUNK_LIMIT)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.add_rx_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) sb.check_decoded(out_tuser, out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (idle_on && !steady_chunk && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_chunk();
    steady_chunk = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < chunk.size(); n++) send_byte(chunk[n], n == chunk.size() - 1);
    chunks_sent++;
  endtask

  // A well-formed frame; a negative fill gives random header, payload and trailing bytes.
  task automatic make_frame(int len, int trailing, int fill);
    logic [7:0] acc;
    logic [7:0] b;
    chunk.delete();
    if (len + 4 + trailing < MIN_FRAME) trailing = MIN_FRAME - len - 4;
    chunk.insert(chunk.size(), SYNC_FIRST);
    chunk.insert(chunk.size(), SYNC_SECOND);
    chunk.insert(chunk.size(), 8'(len));
    acc = 8'(len);
    for (int off = 3; off < len + 3; off++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      acc ^= b;
      chunk.insert(chunk.size(), b);
    end
    chunk.insert(chunk.size(), acc);
    repeat (trailing) chunk.insert(chunk.size(), (fill < 0) ? 8'($urandom) : 8'(fill));
  endtask

  task automatic make_noise(int count);
    chunk.delete();
    repeat (count) chunk.insert(chunk.size(), 8'($urandom));
  endtask

  initial begin
    int         kind;
    int         len;
    int         trail;
    int         keep;
    int         pos;
    logic [7:0] flip;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    make_frame(17, 0, -1);
    send_chunk();
    make_frame(20, 0, 8'hFF);
    send_chunk();
    make_frame(13, 1, 8'h00);
    send_chunk();
    make_frame(16, 0, -1);
    send_chunk();
    make_frame(0, 14, -1);
    send_chunk();
    make_frame(17, 5, -1);
    send_chunk();
    make_frame(255, 0, -1);
    send_chunk();
    make_frame(18, 0, -1);
    chunk[21] ^= 8'h01;
    send_chunk();
    make_frame(18, 0, -1);
    chunk[0] = 8'hAB;
    send_chunk();
    make_frame(18, 0, -1);
    chunk[1] = 8'h54;
    send_chunk();
    make_frame(30, 0, -1);
    repeat (5) void'(chunk.pop_back());
    send_chunk();
    make_frame(30, 0, -1);
    chunk[0] = 8'h00;
    repeat (5) void'(chunk.pop_back());
    send_chunk();
    make_noise(1);
    send_chunk();
    make_noise(17);
    send_chunk();

    // Hold the result side off while short chunks keep coming, so the input stalls.
    hold_req = 1'b1;
    repeat (4) begin
      make_noise(3);
      send_chunk();
    end

    bytes_sent = 0;
    chunks_sent = 0;
    while (bytes_sent < RANDOM_BYTES || chunks_sent < RANDOM_CHUNKS) begin
      idle_on = (bytes_sent < RANDOM_BYTES * 4 / 5);
      kind = $urandom_range(0, 99);
      len = $urandom_range(0, 24);
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (kind < 65) begin
        make_frame(len, trail, -1);
      end else if (kind < 75) begin
        make_frame(len, trail, -1);
        flip = 8'(1 << $urandom_range(0, 7));
        chunk[len + 3] ^= flip;
      end else if (kind < 82) begin
        make_frame(len, trail, -1);
        pos = $urandom_range(0, 1);
        flip = 8'($urandom_range(1, 255));
        chunk[pos] ^= flip;
      end else if (kind < 89) begin
        len = $urandom_range(15, 40);
        make_frame(len, 0, -1);
        keep = $urandom_range(MIN_FRAME, len + 3);
        while (chunk.size() > keep) void'(chunk.pop_back());
      end else if (kind < 95) begin
        make_noise($urandom_range(1, 15));
        if ($urandom_range(0, 1) == 1) begin
          chunk.push_front(SYNC_SECOND);
          chunk.push_front(SYNC_FIRST);
        end
      end else begin
        make_noise($urandom_range(1, 40));
      end
      send_chunk();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
